// ----- rtl/fat_pkg.sv -----
// Package for the flash address translator: payload types, codes and helper functions.
package fat_pkg;

  localparam int DESCR_BYTES  = 32;
  localparam int IDX_W        = 64 - $clog2(DESCR_BYTES);
  localparam int BITS_PER_STG = 4;
  localparam int NS1          = (IDX_W + BITS_PER_STG - 1) / BITS_PER_STG;
  localparam int NS2          = 16 / BITS_PER_STG;
  localparam int NS3          = 8 / BITS_PER_STG;
  localparam int NDIV         = NS1 + NS2 + NS3;
  localparam int ACC_W        = NS1 * BITS_PER_STG;
  localparam int REM_W        = 33;
  localparam int LATENCY      = NDIV + 5;

  typedef enum logic [2:0] {
    CFG_SPEC_MODE     = 3'd0,
    CFG_FIELD_OFFSETS = 3'd1,
    CFG_FIELD_LENGTHS = 3'd2,
    CFG_GEOM_CLASSIC  = 3'd3,
    CFG_GEOM_CHUNKED  = 3'd4,
    CFG_SECTOR_SHIFT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_FIELDS      = 2'd0,
    OP_DEV_ADDR    = 2'd1,
    OP_BYTE_OFFSET = 2'd2,
    OP_REPORT      = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  group_or_channel;
    logic [7:0]  unit_or_lun;
    logic [15:0] chunk_or_plane;
    logic [23:0] block_or_sector;
    logic [15:0] page_index;
    logic [7:0]  sector_in_page;
    logic [63:0] raw_value;
  } req_t;

  typedef struct packed {
    logic [7:0]  out_group_or_channel;
    logic [7:0]  out_unit_or_lun;
    logic [15:0] out_chunk_or_plane;
    logic [23:0] out_block_or_sector;
    logic [15:0] out_page;
    logic [7:0]  out_sector_in_page;
    logic [63:0] device_address;
    logic [63:0] byte_offset;
    logic [63:0] report_offset;
    logic [5:0]  bounds_flags;
  } rsp_t;

  typedef struct packed {
    logic             chunk;
    logic [1:0]       op;
    logic             zero01;
    logic             zero2;
    logic [5:0][23:0] f;
    logic [REM_W-1:0] d;
    logic [REM_W-1:0] rem;
    logic [ACC_W-1:0] acc;
    logic [15:0]      r2;
    logic [63:0]      dev;
    logic [5:0]       flags;
    logic [15:0]      a;
  } pipe_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [ACC_W-1:0] acc;
  } step_t;

  function automatic int field_w(input logic chunk, input int i);
    int w;
    w = 0;
    case (i)
      0: w = 8;
      1: w = 8;
      2: w = chunk ? 16 : 8;
      3: w = chunk ? 24 : 16;
      4: w = chunk ? 0 : 16;
      5: w = chunk ? 0 : 8;
      default: w = 0;
    endcase
    return w;
  endfunction

  function automatic logic [23:0] field_mask(input logic chunk, input int i);
    logic [24:0] one;
    one = 25'(1) << field_w(chunk, i);
    return 24'(one - 25'(1));
  endfunction

  function automatic logic [63:0] len_mask(input logic [5:0] len);
    return (64'(1) << len) - 64'(1);
  endfunction

  function automatic logic [23:0] field_cnt(input logic chunk, input logic [63:0] gc,
                                             input logic [55:0] gk, input int i);
    logic [23:0] c;
    c = '0;
    case (i)
      0: c = chunk ? 24'(gk[7:0])   : 24'(gc[7:0]);
      1: c = chunk ? 24'(gk[15:8])  : 24'(gc[15:8]);
      2: c = chunk ? 24'(gk[31:16]) : 24'(gc[23:16]);
      3: c = chunk ? gk[55:32]      : 24'(gc[39:24]);
      4: c = chunk ? 24'(0)         : 24'(gc[55:40]);
      5: c = chunk ? 24'(0)         : 24'(gc[63:56]);
      default: c = '0;
    endcase
    return c;
  endfunction

  // One restoring step: bring in the next dividend bit, subtract when it fits.
  function automatic step_t div_step(input logic [REM_W-1:0] rem,
                                     input logic [ACC_W-1:0] acc,
                                     input logic [REM_W-1:0] dvs);
    logic [REM_W-1:0] t;
    logic             ge;
    step_t            r;
    t     = {rem[REM_W-2:0], acc[ACC_W-1]};
    ge    = (t >= dvs);
    r.rem = ge ? t - dvs : t;
    r.acc = {acc[ACC_W-2:0], ge};
    return r;
  endfunction

endpackage

// ----- rtl/flash_address_translator.sv -----
// Flash address translator: pipelined field/device/byte/report address conversion.
//
// Usage: drive req_i and raise start_i; a request is taken at every rising edge
// with start_i high and busy_o low. busy_o stays low, so one request can enter
// per cycle. Each request gives one result on rsp_o, marked by done_o for a
// single cycle, in request order. The receiver cannot hold results off.
// The pipeline holds, in order: one decode stage, one stage forming the combined
// divisor, NDIV long-division stages at four bits each (report offset split into
// chunk, unit and group), two stages for field assembly and packing, and the
// output register. Throughput is one request per cycle, set by that division pipeline.
// The configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
// is always ready; write registers only while no request is in flight.
// Reset clears the configuration registers and valid bits to zero and empties
// the pipeline; results of requests in flight at reset are dropped.
module flash_address_translator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  fat_pkg::req_t       req_i,
  output logic                done_o,
  output fat_pkg::rsp_t       rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);
  import fat_pkg::*;

  // Configuration registers
  logic        spec_mode_q;
  logic [35:0] field_offsets_q;
  logic [35:0] field_lengths_q;
  logic [63:0] geom_classic_q;
  logic [55:0] geom_chunked_q;
  logic [3:0]  sector_shift_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_mode_q     <= 1'b0;
      field_offsets_q <= '0;
      field_lengths_q <= '0;
      geom_classic_q  <= '0;
      geom_chunked_q  <= '0;
      sector_shift_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPEC_MODE:     spec_mode_q     <= cfg_data_i[0];
        CFG_FIELD_OFFSETS: field_offsets_q <= cfg_data_i[35:0];
        CFG_FIELD_LENGTHS: field_lengths_q <= cfg_data_i[35:0];
        CFG_GEOM_CLASSIC:  geom_classic_q  <= cfg_data_i;
        CFG_GEOM_CHUNKED:  geom_chunked_q  <= cfg_data_i[55:0];
        CFG_SECTOR_SHIFT:  sector_shift_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Chunked-geometry counts used by the report split
  logic [7:0]  cnt0, cnt1;
  logic [15:0] cnt2;
  assign cnt0 = geom_chunked_q[7:0];
  assign cnt1 = geom_chunked_q[15:8];
  assign cnt2 = geom_chunked_q[31:16];

  logic req_take;
  assign req_take = start_i && !busy_o;

  // Stage 0: decode the request into fields, set up the report division.
  // The report split uses D = chunks * M, with M = units * groups (units when
  // groups is zero, one when units is zero), so a single remainder of the
  // descriptor index by D carries all three fields.
  pipe_t            s0_d, s0_q;
  logic             s0_v_q;
  logic [63:0]      dec_src;
  logic [5:0][23:0] fin;
  logic [63:0]      dec;
  logic [15:0]      m_val;

  always_comb begin
    fin = {24'(req_i.sector_in_page), 24'(req_i.page_index), req_i.block_or_sector,
           24'(req_i.chunk_or_plane), 24'(req_i.unit_or_lun), 24'(req_i.group_or_channel)};
    dec_src = (op_e'(req_i.opcode) == OP_BYTE_OFFSET) ?
              (req_i.raw_value >> sector_shift_q) : req_i.raw_value;
    dec = '0;
    s0_d = '0;
    s0_d.chunk  = spec_mode_q;
    s0_d.op     = req_i.opcode;
    s0_d.zero01 = (cnt1 == 8'd0) || (cnt2 == 16'd0);
    s0_d.zero2  = (cnt2 == 16'd0);
    for (int i = 0; i < 6; i++) begin
      dec = (dec_src >> field_offsets_q[6*i +: 6]) & len_mask(field_lengths_q[6*i +: 6]);
      case (op_e'(req_i.opcode))
        OP_FIELDS: s0_d.f[i] = fin[i] & field_mask(spec_mode_q, i);
        OP_REPORT: s0_d.f[i] = '0;
        default:   s0_d.f[i] = dec[23:0] & field_mask(spec_mode_q, i);
      endcase
    end
    if (cnt1 == 8'd0) begin
      m_val = 16'd1;
    end else if (cnt0 == 8'd0) begin
      m_val = 16'(cnt1);
    end else begin
      m_val = 16'(cnt1 * cnt0);
    end
    s0_d.d   = REM_W'(m_val);
    s0_d.rem = '0;
    s0_d.acc = ACC_W'(req_i.raw_value / DESCR_BYTES);
  end

  // Stage 1: form the combined divisor
  pipe_t s1_d, s1_q;
  logic  s1_v_q;

  always_comb begin
    s1_d   = s0_q;
    s1_d.d = REM_W'(32'(s0_q.d[15:0] * cnt2));
  end

  // Division stages: remainder by D, then by chunks, then by units
  pipe_t div_q [NDIV];
  logic  div_v_q [NDIV];

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    pipe_t            src;
    logic             src_v;
    pipe_t            p;
    step_t            st;
    logic [REM_W-1:0] dvs;

    if (k == 0) begin : g_first
      assign src   = s1_q;
      assign src_v = s1_v_q;
    end else begin : g_next
      assign src   = div_q[k-1];
      assign src_v = div_v_q[k-1];
    end

    always_comb begin
      p  = src;
      st = '0;
      if (k == NS1) begin
        // Reload: the index remainder R splits into R / chunks and R % chunks.
        p.rem = REM_W'(src.rem[31:16]);
        p.acc = {src.rem[15:0], {(ACC_W-16){1'b0}}};
      end
      if (k == NS1 + NS2) begin
        // Hold the chunk remainder, split the quotient by units.
        p.r2  = src.rem[15:0];
        p.rem = REM_W'(src.acc[15:8]);
        p.acc = {src.acc[7:0], {(ACC_W-8){1'b0}}};
      end
      if (k < NS1) begin
        dvs = p.d;
      end else if (k < NS1 + NS2) begin
        dvs = REM_W'(cnt2);
      end else begin
        dvs = REM_W'(cnt1);
      end
      for (int s = 0; s < BITS_PER_STG; s++) begin
        st    = div_step(p.rem, p.acc, dvs);
        p.rem = st.rem;
        p.acc = st.acc;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k] <= 1'b0;
      end else begin
        div_v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[k] <= p;
    end
  end

  // Stage E1: settle report fields
  pipe_t e1_d, e1_q;
  logic  e1_v_q;
  pipe_t dl;
  assign dl = div_q[NDIV-1];

  always_comb begin
    e1_d = dl;
    if ((op_e'(dl.op) == OP_REPORT) && dl.chunk) begin
      e1_d.f[2] = dl.zero2 ? 24'd0 : 24'(dl.r2);
      e1_d.f[1] = dl.zero01 ? 24'd0 : 24'(dl.rem[7:0]);
      e1_d.f[0] = (dl.zero01 || (cnt0 == 8'd0)) ? 24'd0 : 24'(dl.acc[7:0]);
      e1_d.f[3] = '0;
    end
  end

  // Stage E2: pack the device address, check bounds, start the report sum
  pipe_t e2_d, e2_q;
  logic  e2_v_q;

  always_comb begin
    e2_d       = e1_q;
    e2_d.dev   = '0;
    e2_d.flags = '0;
    for (int i = 0; i < 6; i++) begin
      if (field_w(e1_q.chunk, i) != 0) begin
        e2_d.dev      = e2_d.dev | (64'(e1_q.f[i]) << field_offsets_q[6*i +: 6]);
        e2_d.flags[i] = (e1_q.f[i] >= field_cnt(e1_q.chunk, geom_classic_q,
                                                 geom_chunked_q, i));
      end
    end
    e2_d.a = 16'(e1_q.f[0][7:0] * cnt1) + 16'(e1_q.f[1][7:0]);
  end

  // Output stage
  rsp_t        rsp_d, rsp_q;
  logic        done_q;
  logic        out_chunk_q;
  logic [31:0] rpt_sum;

  always_comb begin
    rpt_sum = 32'(e2_q.a * cnt2) + 32'(e2_q.f[2][15:0]);
    rsp_d.out_group_or_channel = e2_q.f[0][7:0];
    rsp_d.out_unit_or_lun      = e2_q.f[1][7:0];
    rsp_d.out_chunk_or_plane   = e2_q.f[2][15:0];
    rsp_d.out_block_or_sector  = e2_q.f[3];
    rsp_d.out_page             = e2_q.f[4][15:0];
    rsp_d.out_sector_in_page   = e2_q.f[5][7:0];
    rsp_d.device_address       = e2_q.dev;
    rsp_d.byte_offset          = e2_q.dev << sector_shift_q;
    rsp_d.report_offset        = e2_q.chunk ? 64'(64'(rpt_sum) * 64'(DESCR_BYTES)) : 64'd0;
    rsp_d.bounds_flags         = e2_q.flags;
  end

  // Valid bits advance every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s0_v_q <= req_take;
      s1_v_q <= s0_v_q;
      e1_v_q <= div_v_q[NDIV-1];
      e2_v_q <= e1_v_q;
      done_q <= e2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q        <= s0_d;
    s1_q        <= s1_d;
    e1_q        <= e1_d;
    e2_q        <= e2_d;
    rsp_q       <= rsp_d;
    out_chunk_q <= e2_q.chunk;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Every request taken comes out of the pipeline on done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take |-> ##LATENCY done_o)
    else $error("request lost in pipeline");

  // Classic mode never yields a report offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_chunk_q) |-> (rsp_o.report_offset == 64'd0))
    else $error("report offset in classic mode");

  // Chunked mode has no page or sector-in-page field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_chunk_q) |-> (rsp_o.out_page == 16'd0 &&
      rsp_o.out_sector_in_page == 8'd0 && rsp_o.bounds_flags[5:4] == 2'b00))
    else $error("classic-only field set in chunked mode");

endmodule
